FILE: hw/rtl/windowed_rate_level_classifier_macros.svh
// Assertion macros shared by the windowed rate level classifier RTL.
`ifndef WINDOWED_RATE_LEVEL_CLASSIFIER_MACROS_SVH
`define WINDOWED_RATE_LEVEL_CLASSIFIER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define WRLC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define WRLC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WRLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/wrlc_pkg.sv
// Types and constants of the windowed rate level classifier.
package wrlc_pkg;

  localparam int STAMP_W    = 48;
  localparam int PCT_W      = 16;
  localparam int THR_W      = 20;
  localparam int LEVEL_W    = 2;
  localparam int HELD_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Shared multiplier: 20 x 24 bits, products are summed in 24-bit chunks.
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + MUL_B_W;
  localparam int LHS_W   = 52;
  localparam int CMP_W   = ACC_W + 8;

  // 60 * 10^9 split into a low 24-bit and a high 12-bit chunk.
  localparam logic [MUL_B_W-1:0] RATE_LO = 24'h475800;
  localparam logic [MUL_B_W-1:0] RATE_HI = 24'h000DF8;

  localparam logic [THR_W-1:0]   NORMAL_RST     = 20'd100;
  localparam logic [THR_W-1:0]   ACTIVE_RST     = 20'd200;
  localparam logic [THR_W-1:0]   HEAVY_RST      = 20'd330;
  localparam logic [STAMP_W-1:0] MIN_WINDOW_RST = 48'd240000000;
  localparam logic [PCT_W-1:0]   DROP_TOL_RST   = 16'd1280;

  localparam logic [LEVEL_W-1:0] LVL_IDLE  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_HEAVY = 2'd3;

  // Multiply steps: 0 and 1 build the rise term, then two steps per threshold.
  localparam logic [2:0] STEP_FIRST  = 3'd0;
  localparam logic [2:0] STEP_LHS_HI = 3'd1;
  localparam logic [2:0] STEP_LAST   = 3'd7;

  typedef enum logic [0:0] {
    OP_STORE = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL     = 3'd0,
    CFG_ACTIVE     = 3'd1,
    CFG_HEAVY      = 3'd2,
    CFG_MIN_WINDOW = 3'd3,
    CFG_DROP_TOL   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_READ,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_CMP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

FILE: hw/rtl/wrlc_ram.sv
// Generic single-port-write, registered-read RAM.
module wrlc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/wrlc_mul.sv
// Shared 20 x 24 bit multiplier with a registered product.
module wrlc_mul
  import wrlc_pkg::*;
(
  input  logic              clk_i,
  input  mul_req_t          req_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= PROD_W'(req_i.a) * PROD_W'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: hw/rtl/windowed_rate_level_classifier.sv
// Top level of the windowed rate level classifier.
//
//   channel  | direction | handshake                      | payload
//   ---------+-----------+--------------------------------+-------------------------------
//   s_axis   | in        | s_axis_tvalid_i/s_axis_tready_o | tuser: opcode; tdata: stamp, pct
//   m_axis   | out       | m_axis_tvalid_o/m_axis_tready_i | tdata: level, held_count
//   cfg      | in        | cfg_we_i                       | cfg_idx_i, cfg_wdata_i
//
// A clear, or an item that leaves fewer than two samples held, goes from the update
// step straight to the finish step; a span below the window ends after the difference
// step; otherwise up to eight multiply/accumulate passes through the one shared
// multiplier and up to three threshold compares come first. A new item is taken again once
// the result is loaded into the output register. The output register holds one
// result while the next item is at work; a stalled output stalls only the last step.
// Reset clears the ring pointers and loads the register defaults; no clearing pass.
`include "windowed_rate_level_classifier_macros.svh"

module windowed_rate_level_classifier
  import wrlc_pkg::*;
#(
  parameter int RING_DEPTH = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [63:0]           s_axis_tdata_i,  // [47:0] stamp_us, [63:48] percent
  input  logic [0:0]            s_axis_tuser_i,  // [0] opcode
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,  // [1:0] level, [4:2] held_count, [7:5] zero
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int WP_W   = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = WP_W + 1;
  localparam int ENTRY_W = STAMP_W + PCT_W;

  state_e                 state_q, state_d;
  logic [2:0]             step_q, step_d;
  op_e                    op_q, op_d;
  logic [STAMP_W-1:0]     stamp_q, stamp_d;
  logic [PCT_W-1:0]       pct_q, pct_d;
  logic [PCT_W-1:0]       last_pct_q, last_pct_d;
  logic [WP_W-1:0]        wp_q, wp_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [STAMP_W-1:0]     dt_q, dt_d;
  logic [PCT_W-1:0]       dp_q, dp_d;
  logic [LHS_W-1:0]       lhs_q, lhs_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [LEVEL_W-1:0]     level_q, level_d;
  logic                   out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]     out_level_q, out_level_d;
  logic [HELD_W-1:0]      out_held_q, out_held_d;

  logic [THR_W-1:0]       normal_thr_q, active_thr_q, heavy_thr_q;
  logic [STAMP_W-1:0]     min_win_q;
  logic [PCT_W-1:0]       drop_tol_q;

  logic                   ram_we, ram_re;
  logic [WP_W-1:0]        ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  mul_req_t               mul_req;
  logic [PROD_W-1:0]      prod;

  logic                   in_xfer;
  logic                   restart;
  logic [WP_W-1:0]        wp_base, wp_next, oldest;
  logic [FILL_W-1:0]      fill_base, fill_next;
  logic [SUM_W-1:0]       back_sum;
  logic [STAMP_W-1:0]     old_stamp, dt_calc;
  logic [PCT_W-1:0]       old_pct, dp_calc;
  logic                   short_span;
  logic [ACC_W-1:0]       prod_shift, acc_sum;
  logic                   below;
  logic                   out_free;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // A clear, or a fall of more than the tolerance below the newest held value, restarts the ring.
  assign restart = (op_q == OP_CLEAR) ||
                   ((fill_q != '0) &&
                    (({1'b0, pct_q} + {1'b0, drop_tol_q}) < {1'b0, last_pct_q}));
  assign wp_base   = restart ? '0 : wp_q;
  assign fill_base = restart ? '0 : fill_q;
  assign wp_next   = (wp_base == WP_W'(RING_DEPTH - 1)) ? '0 : wp_base + WP_W'(1);
  assign fill_next = (fill_base == FILL_W'(RING_DEPTH)) ? fill_base
                                                        : fill_base + FILL_W'(1);

  // Oldest held entry, from the pointers after the store.
  assign back_sum = SUM_W'(wp_q) + SUM_W'(RING_DEPTH) - SUM_W'(fill_q);
  assign oldest   = (back_sum >= SUM_W'(RING_DEPTH)) ? WP_W'(back_sum - SUM_W'(RING_DEPTH))
                                                     : WP_W'(back_sum);

  assign old_stamp  = ram_rdata[ENTRY_W-1:PCT_W];
  assign old_pct    = ram_rdata[PCT_W-1:0];
  assign dt_calc    = stamp_q - old_stamp;
  assign dp_calc    = (pct_q > old_pct) ? pct_q - old_pct : '0;
  assign short_span = dt_calc < min_win_q;

  // Odd steps carry the upper chunk of the 24-bit split.
  assign prod_shift = step_q[0] ? {prod, {MUL_B_W{1'b0}}} : ACC_W'(prod);
  assign acc_sum    = (step_q[0] ? acc_q : '0) + prod_shift;
  assign below      = CMP_W'(lhs_q) < {acc_q, 8'h00};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (op_q == OP_CLEAR || fill_base == '0) state_d = ST_FIN;
        else state_d = ST_READ;
      end
      ST_READ: state_d = ST_DIFF;
      ST_DIFF: begin
        state_d = short_span ? ST_FIN : ST_MUL;
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (step_q[0] && step_q != STEP_LHS_HI) state_d = ST_CMP;
        else state_d = ST_MUL;
      end
      ST_CMP: begin
        if (below || step_q == STEP_LAST) state_d = ST_FIN;
        else state_d = ST_MUL;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    stamp_d     = stamp_q;
    pct_d       = pct_q;
    last_pct_d  = last_pct_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    dt_d        = dt_q;
    dp_d        = dp_q;
    lhs_d       = lhs_q;
    acc_d       = acc_q;
    step_d      = step_q;
    level_d     = level_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_level_d = out_level_q;
    out_held_d  = out_held_q;
    ram_we      = 1'b0;
    ram_waddr   = wp_base;
    ram_re      = 1'b0;
    ram_raddr   = oldest;
    mul_req     = '0;
    s_axis_tready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          op_d    = op_e'(s_axis_tuser_i[0]);
          stamp_d = s_axis_tdata_i[STAMP_W-1:0];
          pct_d   = s_axis_tdata_i[ENTRY_W-1:STAMP_W];
        end
      end
      ST_UPDATE: begin
        level_d = LVL_IDLE;
        if (op_q == OP_CLEAR) begin
          wp_d   = '0;
          fill_d = '0;
        end else begin
          ram_we     = 1'b1;
          wp_d       = wp_next;
          fill_d     = fill_next;
          last_pct_d = pct_q;
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_DIFF: begin
        dt_d   = dt_calc;
        dp_d   = dp_calc;
        step_d = STEP_FIRST;
      end
      ST_MUL: begin
        mul_req.en = 1'b1;
        case (step_q[2:1])
          2'd0:    mul_req.a = MUL_A_W'(dp_q);
          2'd1:    mul_req.a = normal_thr_q;
          2'd2:    mul_req.a = active_thr_q;
          default: mul_req.a = heavy_thr_q;
        endcase
        if (step_q[2:1] == 2'd0) begin
          mul_req.b = step_q[0] ? RATE_HI : RATE_LO;
        end else begin
          mul_req.b = step_q[0] ? dt_q[STAMP_W-1:MUL_B_W] : dt_q[MUL_B_W-1:0];
        end
      end
      ST_ACC: begin
        acc_d = acc_sum;
        if (step_q == STEP_LHS_HI) lhs_d = LHS_W'(acc_sum);
        if (!(step_q[0] && step_q != STEP_LHS_HI)) step_d = step_q + 3'd1;
      end
      ST_CMP: begin
        if (below) begin
          level_d = step_q[2:1] - 2'd1;
        end else if (step_q == STEP_LAST) begin
          level_d = LVL_HEAVY;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_level_d = level_q;
          out_held_d  = HELD_W'(fill_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wp_q         <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
      normal_thr_q <= NORMAL_RST;
      active_thr_q <= ACTIVE_RST;
      heavy_thr_q  <= HEAVY_RST;
      min_win_q    <= MIN_WINDOW_RST;
      drop_tol_q   <= DROP_TOL_RST;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NORMAL:     normal_thr_q <= cfg_wdata_i[THR_W-1:0];
          CFG_ACTIVE:     active_thr_q <= cfg_wdata_i[THR_W-1:0];
          CFG_HEAVY:      heavy_thr_q  <= cfg_wdata_i[THR_W-1:0];
          CFG_MIN_WINDOW: min_win_q    <= cfg_wdata_i[STAMP_W-1:0];
          CFG_DROP_TOL:   drop_tol_q   <= cfg_wdata_i[PCT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    stamp_q     <= stamp_d;
    pct_q       <= pct_d;
    last_pct_q  <= last_pct_d;
    dt_q        <= dt_d;
    dp_q        <= dp_d;
    lhs_q       <= lhs_d;
    acc_q       <= acc_d;
    step_q      <= step_d;
    level_q     <= level_d;
    out_level_q <= out_level_d;
    out_held_q  <= out_held_d;
  end

  wrlc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({stamp_q, pct_q}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  wrlc_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .prod_o(prod)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_held_q, out_level_q};

  `WRLC_ASSERT(a_fill_range, fill_q <= FILL_W'(RING_DEPTH), "fill count beyond ring depth")
  `WRLC_ASSERT(a_wp_range, ({1'b0, wp_q} < SUM_W'(RING_DEPTH)), "write pointer beyond ring")
  `WRLC_ASSERT_NEXT(a_accept_update, in_xfer, state_q == ST_UPDATE, "transfer did not start update")
  `WRLC_ASSERT_IMPL(a_result_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN, "result without finish")

endmodule

FILE: test/windowed_rate_level_classifier_test.sv
`timescale 1ns / 100ps
// Self-checking stream testbench of the windowed rate level classifier.
module windowed_rate_level_classifier_test
  import wrlc_pkg::*;
();

  localparam int RING_SLOTS = 6;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 129;
  localparam int PHASES = 8;
  localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_ACTIVE = 2'd2;
  localparam logic [127:0] RISE_SCALE = 128'd60000000000;
  localparam logic [STAMP_W-1:0] MINUTE_US = 48'd60000000;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [HELD_W-1:0]  count;
  } level_result_t;

  class level_tracker;
    logic [THR_W-1:0]   normal_thr = NORMAL_RST;
    logic [THR_W-1:0]   active_thr = ACTIVE_RST;
    logic [THR_W-1:0]   heavy_thr = HEAVY_RST;
    logic [STAMP_W-1:0] min_window = MIN_WINDOW_RST;
    logic [PCT_W-1:0]   drop_tol = DROP_TOL_RST;
    logic [STAMP_W-1:0] stamps[RING_SLOTS];
    logic [PCT_W-1:0]   pcts[RING_SLOTS];
    int wr_slot = 0;
    int held = 0;
    int errors = 0;
    int items = 0;
    int clears = 0;
    int level_hits[4] = '{0, 0, 0, 0};
    level_result_t expected_levels[$];

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_NORMAL:     normal_thr = value[THR_W-1:0];
        CFG_ACTIVE:     active_thr = value[THR_W-1:0];
        CFG_HEAVY:      heavy_thr = value[THR_W-1:0];
        CFG_MIN_WINDOW: min_window = value[STAMP_W-1:0];
        CFG_DROP_TOL:   drop_tol = value[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    // Rate below threshold, cross-multiplied so that no division is needed.
    function bit rate_below(logic [THR_W-1:0] thr, logic [PCT_W-1:0] rise,
                            logic [STAMP_W-1:0] span);
      return 128'(rise) * RISE_SCALE < 128'(thr) * 128'd256 * 128'(span);
    endfunction

    function logic [LEVEL_W-1:0] rate_level();
      int oldest;
      int newest;
      logic [STAMP_W-1:0] span;
      logic [PCT_W-1:0] rise;
      if (held < 2) return LVL_IDLE;
      oldest = (wr_slot + RING_SLOTS - held % RING_SLOTS) % RING_SLOTS;
      newest = (wr_slot + RING_SLOTS - 1) % RING_SLOTS;
      span = stamps[newest] - stamps[oldest];
      if (span < min_window) return LVL_IDLE;
      rise = (pcts[newest] > pcts[oldest]) ? pcts[newest] - pcts[oldest] : '0;
      if (rate_below(normal_thr, rise, span)) return LVL_IDLE;
      if (rate_below(active_thr, rise, span)) return LVL_NORMAL;
      if (rate_below(heavy_thr, rise, span)) return LVL_ACTIVE;
      return LVL_HEAVY;
    endfunction

    function void take_sample(op_e op, logic [STAMP_W-1:0] stamp, logic [PCT_W-1:0] pct);
      int newest;
      newest = (wr_slot + RING_SLOTS - 1) % RING_SLOTS;
      items++;
      if (op == OP_CLEAR) begin
        clears++;
        wr_slot = 0;
        held = 0;
      end else begin
        // A fall by more than the tolerance starts a fresh window.
        if (held > 0 && {1'b0, pct} + {1'b0, drop_tol} < {1'b0, pcts[newest]}) begin
          wr_slot = 0;
          held = 0;
        end
        stamps[wr_slot] = stamp;
        pcts[wr_slot] = pct;
        wr_slot = (wr_slot + 1) % RING_SLOTS;
        if (held < RING_SLOTS) held++;
      end
      expected_levels.push_back('{level: rate_level(), count: HELD_W'(held)});
    endfunction

    function void check_level(logic [LEVEL_W-1:0] level, logic [HELD_W-1:0] count);
      level_result_t want;
      if (expected_levels.size() == 0) begin
        $error("result transfer with no item outstanding: level %0d, held_count %0d",
               level, count);
        errors++;
        return;
      end
      want = expected_levels.pop_front();
      level_hits[level]++;
      if (level !== want.level) begin
        $error("level: expected %0d, actual %0d", want.level, level);
        errors++;
      end
      if (count !== want.count) begin
        $error("held_count: expected %0d, actual %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [63:0]           s_axis_tdata_i;   // [47:0] stamp_us, [63:48] percent
  logic [0:0]            s_axis_tuser_i;   // [0] opcode
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [7:0]            m_axis_tdata_o;   // [1:0] level, [4:2] held_count, [7:5] zero
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  logic               calm;
  logic [STAMP_W-1:0] cur_stamp;
  logic [PCT_W-1:0]   cur_pct;
  int                 settings_loaded;
  level_tracker       tracker = new();

  windowed_rate_level_classifier #(
    .RING_DEPTH(RING_SLOTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      tracker.check_level(m_axis_tdata_o[LEVEL_W-1:0],
                          m_axis_tdata_o[LEVEL_W+HELD_W-1:LEVEL_W]);
    end
    m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 10);
  end

  function automatic logic [STAMP_W-1:0] random48();
    return {16'($urandom()), $urandom()};
  endfunction

  task automatic send_item(op_e op, logic [STAMP_W-1:0] stamp, logic [PCT_W-1:0] pct);
    if (!calm && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {pct, stamp};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.take_sample(op, stamp, pct);
  endtask

  task automatic wait_drained();
    while (tracker.expected_levels.size() != 0) @(posedge clk_i);
  endtask

  // Writes all registers back to back, then one index past the last register.
  task automatic load_settings(logic [CFG_DATA_W-1:0] normal, logic [CFG_DATA_W-1:0] active,
                               logic [CFG_DATA_W-1:0] heavy, logic [CFG_DATA_W-1:0] window,
                               logic [CFG_DATA_W-1:0] drop);
    logic [CFG_IDX_W-1:0]  slots[6];
    logic [CFG_DATA_W-1:0] vals[6];
    slots = '{CFG_NORMAL, CFG_ACTIVE, CFG_HEAVY, CFG_MIN_WINDOW, CFG_DROP_TOL,
              CFG_IDX_W'(CFG_DROP_TOL + 1)};
    vals = '{normal, active, heavy, window, drop, random48()};
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    for (int k = 0; k < 6; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= slots[k];
      cfg_wdata_i <= vals[k];
      @(posedge clk_i);
      tracker.set_reg(slots[k], vals[k]);
    end
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // Mostly climbing sample series with random steps, mixed with clears, big
  // falls, fresh series near the stamp wrap and fully random items.
  task automatic run_phase(int count);
    int pick;
    int step;
    op_e op;
    logic [STAMP_W-1:0] stamp;
    logic [PCT_W-1:0] pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      op = OP_STORE;
      if (pick < 3) begin
        op = OP_CLEAR;
        stamp = random48();
        pct = PCT_W'($urandom());
      end else if (pick < 10) begin
        stamp = random48();
        pct = PCT_W'($urandom());
      end else if (pick < 12) begin
        stamp = '1 - STAMP_W'($urandom_range(0, 400000000));
        pct = PCT_W'($urandom_range(0, 4000));
      end else if (pick < 16) begin
        stamp = cur_stamp + STAMP_W'($urandom_range(1000000, 90000000));
        pct = (cur_pct > 16'd3000) ? cur_pct - PCT_W'($urandom_range(1300, 3000))
                                   : PCT_W'($urandom_range(0, 1000));
      end else begin
        stamp = cur_stamp + STAMP_W'($urandom_range(1000000, 150000000));
        step = int'(cur_pct) + int'($urandom_range(0, 260)) - 40;
        if (step < 0) pct = '0;
        else if (step > 65535) pct = '1;
        else pct = PCT_W'(step);
      end
      if (op == OP_STORE) begin
        cur_stamp = stamp;
        cur_pct = pct;
      end
      send_item(op, stamp, pct);
    end
  endtask

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("no transfer for %0d cycles, run stopped", QUIET_LIMIT);
    $display("windowed_rate_level_classifier_test NOT OK");
    $finish;
  end

  initial begin
    int thr_a;
    int thr_b;
    int thr_c;
    int swap;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = OP_STORE;
    m_axis_tready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_NORMAL;
    cfg_wdata_i = '0;
    calm = 1'b0;
    cur_stamp = '0;
    cur_pct = '0;
    settings_loaded = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: window edges, tolerance edges, ring overwrite, wrap.
    send_item(OP_CLEAR, '1, '1);
    send_item(OP_STORE, '0, '0);
    send_item(OP_STORE, MINUTE_US, 16'h2100);
    send_item(OP_STORE, 4 * MINUTE_US, 16'h2200);
    send_item(OP_STORE, 8 * MINUTE_US, 16'h2100);
    send_item(OP_STORE, 9 * MINUTE_US, 16'h2180);
    send_item(OP_STORE, 10 * MINUTE_US, 16'h2200);
    send_item(OP_STORE, 12 * MINUTE_US, 16'h2240);
    send_item(OP_STORE, 13 * MINUTE_US, 16'h2240 - DROP_TOL_RST);
    send_item(OP_STORE, 14 * MINUTE_US, 16'h2240 - DROP_TOL_RST - DROP_TOL_RST - 1);
    send_item(OP_CLEAR, random48(), 16'hFFFF);
    send_item(OP_STORE, '1 - 3 * MINUTE_US, 16'h0000);
    send_item(OP_STORE, '1, 16'h8000);
    send_item(OP_STORE, 2 * MINUTE_US, 16'hFFFF);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_STORE, 20 * MINUTE_US, 16'h8000);
    send_item(OP_STORE, 25 * MINUTE_US, 16'h8000 - 16'd1000);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_settings(CFG_DATA_W'(NORMAL_RST), CFG_DATA_W'(ACTIVE_RST),
                         CFG_DATA_W'(HEAVY_RST), '0, CFG_DATA_W'(DROP_TOL_RST));
        1: load_settings('0, '0, '0, '0, '0);
        2: load_settings(random48() | 48'hFFFFF, random48() | 48'hFFFFF,
                         random48() | 48'hFFFFF, '1, random48() | 48'hFFFF);
        default: begin
          thr_a = $urandom_range(0, 600);
          thr_b = $urandom_range(0, 600);
          thr_c = $urandom_range(0, 600);
          // The last phase keeps the thresholds in random order.
          if (ph != PHASES - 1) begin
            if (thr_a > thr_b) begin swap = thr_a; thr_a = thr_b; thr_b = swap; end
            if (thr_b > thr_c) begin swap = thr_b; thr_b = thr_c; thr_c = swap; end
            if (thr_a > thr_b) begin swap = thr_a; thr_a = thr_b; thr_b = swap; end
          end
          load_settings(CFG_DATA_W'(thr_a), CFG_DATA_W'(thr_b), CFG_DATA_W'(thr_c),
                        CFG_DATA_W'($urandom_range(0, 400000000)),
                        CFG_DATA_W'($urandom_range(0, 4000)));
        end
      endcase
      if (ph == 0) begin
        // With no minimum window a zero span classifies as heavy.
        send_item(OP_STORE, 48'h123456789ABC, 16'h1000);
        send_item(OP_STORE, 48'h123456789ABC, 16'h1100);
        send_item(OP_STORE, 48'h123456789ABC, 16'h1100);
      end
      calm = (ph == 3);
      run_phase(PHASE_ITEMS);
    end
    calm = 1'b0;

    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (30) @(posedge clk_i);
    $display("Sent %0d items (%0d clears) under %0d register settings.",
             tracker.items, tracker.clears, settings_loaded);
    $display("Levels returned 0/1/2/3: %0d/%0d/%0d/%0d.", tracker.level_hits[0],
             tracker.level_hits[1], tracker.level_hits[2], tracker.level_hits[3]);
    if (tracker.errors == 0)
      $display("windowed_rate_level_classifier_test OK");
    else
      $display("windowed_rate_level_classifier_test NOT OK");
    $finish;
  end

endmodule
